// ===== hw/rtl/ufc_pkg.sv =====
// Package for the unescape and XOR frame checker.
// Holds the framing byte codes, status codes, register indexes and result types.
// No dependencies.
package ufc_pkg;

   localparam logic [7:0] ESC_BYTE   = 8'h7E;
   localparam logic [7:0] END_BYTE   = 8'h7F;
   localparam logic [7:0] ESC_FOR_7E = 8'h7D;

   localparam logic [7:0] DATA_START_RESET    = 8'd35;
   localparam logic [7:0] COMMAND_START_RESET = 8'd36;

   localparam logic [2:0] STATUS_DATA_OK      = 3'd0;
   localparam logic [2:0] STATUS_COMMAND_OK   = 3'd1;
   localparam logic [2:0] STATUS_CHECKSUM_BAD = 3'd2;
   localparam logic [2:0] STATUS_UNKNOWN      = 3'd3;
   localparam logic [2:0] STATUS_LENGTH_ERROR = 3'd4;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_START    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND_START = 1'b1;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  data_byte;
      logic        is_last;
      logic [2:0]  frame_status;
      logic [15:0] declared_length;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

endpackage

// ===== hw/rtl/ufc_result_fifo.sv =====
// Four-entry result queue that takes up to two results per cycle and hands out one while out_stall is low.
// Depends on ufc_pkg for the result and push types.
module ufc_result_fifo
   import ufc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  push_type   push,
   output logic       room_for_two,
   output logic       out_valid,
   input  logic       out_stall,
   output result_type out_data
);

   localparam int unsigned DEPTH = 4;
   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   result_type mem_ff [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic pop;
   logic [PTR_W-1:0] tail_next;

   assign out_valid    = (count_ff != '0);
   assign out_data     = mem_ff[head_ff];
   assign pop          = out_valid && !out_stall;
   assign room_for_two = (count_ff <= CNT_W'(DEPTH - 2));
   assign tail_next    = tail_ff + PTR_W'(1);

   always_comb begin
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      tail_in  = tail_ff + PTR_W'(push.count);
      count_in = count_ff + CNT_W'(push.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_next] <= push.second;
      end
   end

endmodule

// ===== hw/rtl/ufc_decoder.sv =====
// Input register, escape decoding, frame bookkeeping and end-of-frame verdict.
// Depends on ufc_pkg for byte codes, status codes and result types.
module ufc_decoder
   import ufc_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_stall,
   input  logic [7:0]             in_byte,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   input  logic                   room_for_two,
   output push_type               push
);

   localparam int unsigned CW = $clog2(MAX_FRAME + 1);

   typedef struct packed {
      logic          esc;
      logic [CW-1:0] count;
      logic [15:0]   len;
      logic [7:0]    xsum;
      logic [7:0]    first;
      logic [7:0]    check;
      logic          ovf;
   } frame_type;

   typedef struct packed {
      frame_type st;
      logic      emit;
   } take_type;

   function automatic take_type take_byte(input frame_type s, input logic [7:0] b);
      take_type t;
      logic [15:0] idx;
      t.st = s;
      t.emit = 1'b0;
      idx = 16'(s.count);
      if (s.count >= CW'(MAX_FRAME)) begin
         t.st.ovf = 1'b1;
      end else begin
         if (s.count == CW'(0)) begin
            t.st.first = b;
         end else if (s.count == CW'(1)) begin
            t.st.len[7:0] = b;
         end else if (s.count == CW'(2)) begin
            t.st.len[15:8] = b;
         end
         t.emit = (s.count < CW'(2)) || (idx < t.st.len);
         if (t.emit) begin
            t.st.xsum = s.xsum ^ b;
         end else if (idx == t.st.len) begin
            t.st.check = b;
         end
         t.st.count = s.count + CW'(1);
      end
      return t;
   endfunction

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic [7:0] data_start_ff, data_start_in;
   logic [7:0] command_start_ff, command_start_in;
   frame_type  state_ff, state_in;

   logic       consume;
   logic       is_end, do_a, do_b;
   logic [7:0] byte_a;
   frame_type  cur, after;
   take_type   ta, tb;
   result_type res_a, res_b, res_end;
   logic [2:0] verdict;

   assign consume  = in_valid_ff && room_for_two;
   assign in_stall = in_valid_ff && !room_for_two;

   always_comb begin
      is_end = (in_byte_ff == END_BYTE);
      cur = state_ff;
      cur.esc = 1'b0;
      if (state_ff.esc && in_byte_ff == ESC_BYTE) begin
         byte_a = END_BYTE;
      end else if (state_ff.esc) begin
         byte_a = ESC_BYTE;
      end else begin
         byte_a = in_byte_ff;
      end
      do_a = state_ff.esc || (in_byte_ff != ESC_BYTE && !is_end);
      do_b = state_ff.esc && in_byte_ff != ESC_FOR_7E && in_byte_ff != ESC_BYTE && !is_end;
      ta = take_byte(cur, byte_a);
      tb = take_byte(ta.st, in_byte_ff);
      if (do_b) begin
         after = tb.st;
      end else if (do_a) begin
         after = ta.st;
      end else begin
         after = cur;
      end

      if (after.count < CW'(3) || after.len < 16'd3 || after.len >= 16'(MAX_FRAME)
          || after.ovf || 16'(after.count) <= after.len) begin
         verdict = STATUS_LENGTH_ERROR;
      end else if (after.xsum != after.check) begin
         verdict = STATUS_CHECKSUM_BAD;
      end else if (after.first == data_start_ff) begin
         verdict = STATUS_DATA_OK;
      end else if (after.first == command_start_ff) begin
         verdict = STATUS_COMMAND_OK;
      end else begin
         verdict = STATUS_UNKNOWN;
      end

      res_a   = '{KIND_BYTE, byte_a, 1'b0, STATUS_DATA_OK, 16'd0};
      res_b   = '{KIND_BYTE, in_byte_ff, 1'b0, STATUS_DATA_OK, 16'd0};
      res_end = '{KIND_STATUS, 8'd0, 1'b1, verdict, after.len};

      push.count  = 2'd0;
      push.first  = res_a;
      push.second = res_b;
      if (consume) begin
         if (do_a && ta.emit) begin
            if (do_b && tb.emit) begin
               push.count = 2'd2;
            end else if (is_end) begin
               push.count  = 2'd2;
               push.second = res_end;
            end else begin
               push.count = 2'd1;
            end
         end else if (do_b && tb.emit) begin
            push.count = 2'd1;
            push.first = res_b;
         end else if (is_end) begin
            push.count = 2'd1;
            push.first = res_end;
         end
      end

      state_in = state_ff;
      if (consume) begin
         if (is_end) begin
            state_in = '0;
         end else if (!state_ff.esc && in_byte_ff == ESC_BYTE) begin
            state_in.esc = 1'b1;
         end else begin
            state_in = after;
         end
      end

      data_start_in    = data_start_ff;
      command_start_in = command_start_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DATA_START:    data_start_in = csr_wdata;
            CSR_COMMAND_START: command_start_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         state_ff         <= '0;
         data_start_ff    <= DATA_START_RESET;
         command_start_ff <= COMMAND_START_RESET;
      end else begin
         if (!in_stall) begin
            in_valid_ff <= in_valid;
         end
         state_ff         <= state_in;
         data_start_ff    <= data_start_in;
         command_start_ff <= command_start_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         in_byte_ff <= in_byte;
      end
   end

endmodule

// ===== hw/rtl/unescape_xor_frame_checker_unit.sv =====
// Byte-stuffing deframer with XOR checksum, top level.
// Instantiates ufc_decoder and ufc_result_fifo; uses ufc_pkg.
//
// The req channel carries one raw received byte per transaction. Escape pairs
// are undone, decoded frame bytes up to the declared length appear on the rsp
// channel, and a raw 0x7F closes the frame with one status transaction.
// A received byte causes zero, one or two rsp transactions.
// A byte is accepted into an input register, decoded from that register once
// the queue has room, and written into a four-entry result queue, which then
// offers its first result on the rsp channel.
// One byte is accepted per cycle; the rate is set by
// the single decode pass, which stalls only while the queue has fewer than two
// free entries. When the receiver stalls, the queue fills and req_stall rises.
// The csr port writes the data and command start codes.
// Reset empties the queue, clears the frame state and restores the start codes.
module unescape_xor_frame_checker_unit
   import ufc_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_result_kind,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_is_last,
   output logic [2:0]             rsp_frame_status,
   output logic [15:0]            rsp_declared_length,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata
);

   push_type   push;
   logic       room_for_two;
   result_type out_data;

   ufc_decoder #(
      .MAX_FRAME(MAX_FRAME)
   ) u_decoder (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_byte      (req_rx_byte),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .room_for_two (room_for_two),
      .push         (push)
   );

   ufc_result_fifo u_result_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room_for_two),
      .out_valid    (rsp_valid),
      .out_stall    (rsp_stall),
      .out_data     (out_data)
   );

   assign rsp_result_kind     = out_data.result_kind;
   assign rsp_data_byte       = out_data.data_byte;
   assign rsp_is_last         = out_data.is_last;
   assign rsp_frame_status    = out_data.frame_status;
   assign rsp_declared_length = out_data.declared_length;

endmodule

// ===== hw/rtl/ufc_checker.sv =====
// Port-level checker for the unescape and XOR frame checker, with its bind.
// Depends on ufc_pkg for codes and on the top level's port names.
module ufc_port_checker
   import ufc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_result_kind,
   input logic [7:0]             rsp_data_byte,
   input logic                   rsp_is_last,
   input logic [2:0]             rsp_frame_status,
   input logic [15:0]            rsp_declared_length
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("stalled transaction withdrawn");

   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_last == rsp_result_kind)
      else $error("is_last does not match result kind");

   a_byte_fields_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_BYTE |->
         rsp_frame_status == STATUS_DATA_OK && rsp_declared_length == 16'd0)
      else $error("byte transaction carries status fields");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_STATUS |->
         rsp_data_byte == 8'd0 && rsp_frame_status <= STATUS_LENGTH_ERROR)
      else $error("malformed status transaction");

endmodule

bind unescape_xor_frame_checker_unit ufc_port_checker u_checker (.*);

// ===== bench/ufc_checker.sv =====
// Checker for the unescape and XOR frame checker: watches the req, rsp and csr ports,
// predicts every rsp transaction from the accepted bytes and compares field by field.
// Depends on ufc_pkg for the byte codes, status codes, register indexes and result type.
`timescale 1ns / 100ps

module ufc_checker
   import ufc_pkg::*;
#(
   parameter int unsigned MAX_FRAME = 512
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [7:0]             req_rx_byte,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_result_kind,
   input  logic [7:0]             rsp_data_byte,
   input  logic                   rsp_is_last,
   input  logic [2:0]             rsp_frame_status,
   input  logic [15:0]            rsp_declared_length,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wdata,
   output int                     fail_count,
   output int                     outstanding
);

   result_type expected_results[$];

   logic [7:0]  data_code;
   logic [7:0]  command_code;
   bit          escape_pending;
   bit          overflow_seen;
   int unsigned byte_count;
   logic [15:0] length_word;
   logic [7:0]  xor_sum;
   logic [7:0]  first_byte;
   logic [7:0]  check_byte;

   task automatic clear_frame();
      escape_pending = 1'b0;
      overflow_seen  = 1'b0;
      byte_count     = 0;
      length_word    = '0;
      xor_sum        = '0;
      first_byte     = '0;
      check_byte     = '0;
   endtask

   task automatic push_result(input logic kind, input logic [7:0] dbyte, input logic last,
                              input logic [2:0] status, input logic [15:0] len);
      result_type r;
      r.result_kind     = kind;
      r.data_byte       = dbyte;
      r.is_last         = last;
      r.frame_status    = status;
      r.declared_length = len;
      expected_results.push_back(r);
   endtask

   task automatic store_decoded(input logic [7:0] b);
      int unsigned idx;
      idx = byte_count;
      if (idx >= MAX_FRAME) begin
         overflow_seen = 1'b1;
         return;
      end
      if (idx == 0)
         first_byte = b;
      else if (idx == 1)
         length_word[7:0] = b;
      else if (idx == 2)
         length_word[15:8] = b;
      if (idx < 2 || idx < length_word) begin
         xor_sum ^= b;
         push_result(KIND_BYTE, b, 1'b0, STATUS_DATA_OK, 16'd0);
      end else if (idx == length_word) begin
         check_byte = b;
      end
      byte_count = idx + 1;
   endtask

   function automatic logic [2:0] frame_verdict();
      if (byte_count < 3 || length_word < 3 || length_word >= MAX_FRAME || overflow_seen ||
          byte_count <= length_word)
         return STATUS_LENGTH_ERROR;
      if (xor_sum != check_byte)
         return STATUS_CHECKSUM_BAD;
      if (first_byte == data_code)
         return STATUS_DATA_OK;
      if (first_byte == command_code)
         return STATUS_COMMAND_OK;
      return STATUS_UNKNOWN;
   endfunction

   task automatic predict_rx(input logic [7:0] b);
      if (b == END_BYTE) begin
         if (escape_pending)
            store_decoded(ESC_BYTE);
         push_result(KIND_STATUS, 8'd0, 1'b1, frame_verdict(), length_word);
         clear_frame();
      end else if (escape_pending) begin
         escape_pending = 1'b0;
         if (b == ESC_FOR_7E) begin
            store_decoded(ESC_BYTE);
         end else if (b == ESC_BYTE) begin
            store_decoded(END_BYTE);
         end else begin
            store_decoded(ESC_BYTE);
            store_decoded(b);
         end
      end else if (b == ESC_BYTE) begin
         escape_pending = 1'b1;
      end else begin
         store_decoded(b);
      end
   endtask

   task automatic check_result();
      result_type want;
      if (expected_results.size() == 0) begin
         $error("rsp transaction with nothing expected: kind %0d, data_byte %0h",
                rsp_result_kind, rsp_data_byte);
         fail_count++;
         return;
      end
      want = expected_results.pop_front();
      if (rsp_result_kind !== want.result_kind) begin
         $error("result_kind: expected %0d, actual %0d", want.result_kind, rsp_result_kind);
         fail_count++;
      end
      if (rsp_data_byte !== want.data_byte) begin
         $error("data_byte: expected %0h, actual %0h", want.data_byte, rsp_data_byte);
         fail_count++;
      end
      if (rsp_is_last !== want.is_last) begin
         $error("is_last: expected %0d, actual %0d", want.is_last, rsp_is_last);
         fail_count++;
      end
      if (rsp_frame_status !== want.frame_status) begin
         $error("frame_status: expected %0d, actual %0d", want.frame_status, rsp_frame_status);
         fail_count++;
      end
      if (rsp_declared_length !== want.declared_length) begin
         $error("declared_length: expected %0h, actual %0h",
                want.declared_length, rsp_declared_length);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         data_code    = DATA_START_RESET;
         command_code = COMMAND_START_RESET;
         clear_frame();
         expected_results.delete();
         fail_count = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_DATA_START:    data_code = csr_wdata;
               CSR_COMMAND_START: command_code = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall)
            check_result();
         if (req_valid && !req_stall)
            predict_rx(req_rx_byte);
      end
      outstanding = expected_results.size();
   end

endmodule

// ===== bench/unescape_xor_frame_checker_unit_tb.sv =====
// Top of the testbench for unescape_xor_frame_checker_unit: drives reset, csr writes,
// encoded frames and noise bytes, and gives the verdict. Uses ufc_checker and ufc_pkg.
`timescale 1ns / 100ps

module unescape_xor_frame_checker_unit_tb
   import ufc_pkg::*;
();

   localparam int unsigned MAX_FRAME       = 512;
   localparam int          WATCHDOG_LIMIT  = 2000;
   localparam int          HOLD_CYCLES     = 300;
   localparam int          ITEMS_PER_PHASE = 95;
   localparam int          SETTLE_CYCLES   = 6;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [7:0]             req_rx_byte;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_result_kind;
   logic [7:0]             rsp_data_byte;
   logic                   rsp_is_last;
   logic [2:0]             rsp_frame_status;
   logic [15:0]            rsp_declared_length;
   logic                   csr_wr_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [7:0]             csr_wdata;

   int         fail_count;
   int         outstanding;
   int         bytes_sent = 0;
   int         stall_cycles = 0;
   int         phase_end;
   bit         idling = 1'b1;
   bit         hold_pending = 1'b0;
   logic [7:0] data_code = DATA_START_RESET;
   logic [7:0] command_code = COMMAND_START_RESET;
   logic [7:0] frame_bytes[$];

   unescape_xor_frame_checker_unit #(.MAX_FRAME(MAX_FRAME)) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_is_last(rsp_is_last),
      .rsp_frame_status(rsp_frame_status),
      .rsp_declared_length(rsp_declared_length),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   ufc_checker #(.MAX_FRAME(MAX_FRAME)) frame_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_data_byte(rsp_data_byte),
      .rsp_is_last(rsp_is_last),
      .rsp_frame_status(rsp_frame_status),
      .rsp_declared_length(rsp_declared_length),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .fail_count(fail_count),
      .outstanding(outstanding)
   );

   always #1 clock = ~clock;

   // The watchdog restarts on every accepted transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            rsp_stall = idling && ($urandom_range(99) < 34);
         end
      end
   end

   function automatic logic [7:0] random_data();
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(2))
               0:       return ESC_FOR_7E;
               1:       return ESC_BYTE;
               default: return END_BYTE;
            endcase
         end
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   task automatic send_raw(input logic [7:0] b);
      @(negedge clock);
      if (idling && $urandom_range(99) < 34) begin
         req_valid = 1'b0;
         do
            @(negedge clock);
         while ($urandom_range(99) < 34);
      end
      req_valid   = 1'b1;
      req_rx_byte = b;
      do
         @(posedge clock);
      while (req_stall);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic build_frame(input logic [7:0] start, input logic [15:0] length,
                              input bit bad_sum, input int unsigned extra);
      int unsigned body;
      logic [7:0]  sum;
      frame_bytes.delete();
      frame_bytes.push_back(start);
      frame_bytes.push_back(length[7:0]);
      frame_bytes.push_back(length[15:8]);
      body = (length > 3) ? length - 3 : 0;
      if (length >= 600)
         body = $urandom_range(5);
      repeat (body) frame_bytes.push_back(random_data());
      if (length >= 3 && length < 600) begin
         sum = '0;
         foreach (frame_bytes[i])
            sum ^= frame_bytes[i];
         if (bad_sum)
            sum ^= 8'($urandom_range(255, 1));
         frame_bytes.push_back(sum);
      end
      repeat (extra) frame_bytes.push_back(random_data());
   endtask

   // A decoded 0x7E is sometimes sent as a lone escape where the next raw byte allows it.
   task automatic send_frame();
      logic [7:0] next_byte;
      bit         lone_ok;
      foreach (frame_bytes[i]) begin
         if (frame_bytes[i] == ESC_BYTE) begin
            lone_ok = 1'b1;
            if (i + 1 < frame_bytes.size()) begin
               next_byte = frame_bytes[i + 1];
               lone_ok = next_byte != ESC_FOR_7E && next_byte != ESC_BYTE &&
                         next_byte != END_BYTE;
            end
            send_raw(ESC_BYTE);
            if (!lone_ok || $urandom_range(3) != 0)
               send_raw(ESC_FOR_7E);
         end else if (frame_bytes[i] == END_BYTE) begin
            send_raw(ESC_BYTE);
            send_raw(ESC_BYTE);
         end else begin
            send_raw(frame_bytes[i]);
         end
      end
      send_raw(END_BYTE);
   endtask

   task automatic random_frame();
      logic [7:0]  start;
      logic [15:0] length;
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 4)
         start = data_code;
      else if (pick < 7)
         start = command_code;
      else
         start = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 4)
         length = 16'($urandom_range(2));
      else if (pick < 8)
         length = 16'($urandom_range(65535));
      else if (pick < 12)
         length = 16'($urandom_range(120, 25));
      else
         length = 16'($urandom_range(16, 3));
      build_frame(start, length, $urandom_range(99) < 15,
                  ($urandom_range(99) < 15) ? $urandom_range(3, 1) : 0);
      if ($urandom_range(99) < 8)
         repeat ($urandom_range(frame_bytes.size(), 1)) void'(frame_bytes.pop_back());
      send_frame();
   endtask

   task automatic send_noise();
      repeat ($urandom_range(6, 1)) send_raw(random_data());
      if ($urandom_range(1))
         send_raw(END_BYTE);
   endtask

   task automatic random_traffic(input int count);
      phase_end = bytes_sent + count;
      while (bytes_sent < phase_end) begin
         if ($urandom_range(99) < 80)
            random_frame();
         else
            send_noise();
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_rx_byte = '0;
      csr_wr_en   = 1'b0;
      csr_index   = CSR_DATA_START;
      csr_wdata   = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Shortest valid data frame.
      build_frame(DATA_START_RESET, 16'd3, 1'b0, 0);
      send_frame();
      // Command frame whose payload carries both escaped codes.
      frame_bytes.delete();
      frame_bytes.push_back(COMMAND_START_RESET);
      frame_bytes.push_back(8'd5);
      frame_bytes.push_back(8'd0);
      frame_bytes.push_back(ESC_BYTE);
      frame_bytes.push_back(END_BYTE);
      frame_bytes.push_back(COMMAND_START_RESET ^ 8'd5 ^ ESC_BYTE ^ END_BYTE);
      send_frame();
      // Frame ending after a single byte.
      send_raw(DATA_START_RESET);
      send_raw(END_BYTE);
      // An escape left pending when the frame ends.
      send_raw(8'h11);
      send_raw(ESC_BYTE);
      send_raw(END_BYTE);
      // A lone escape kept as data, then the field extremes.
      send_raw(ESC_BYTE);
      send_raw(8'h41);
      send_raw(8'hFF);
      send_raw(8'h00);
      send_raw(END_BYTE);

      random_traffic(ITEMS_PER_PHASE);

      wait_idle();
      data_code    = 8'd0;
      command_code = 8'd255;
      write_csr(CSR_DATA_START, data_code);
      write_csr(CSR_COMMAND_START, command_code);
      build_frame(data_code, 16'd20, 1'b0, 3);
      send_frame();
      random_traffic(ITEMS_PER_PHASE);

      wait_idle();
      data_code    = 8'($urandom_range(255));
      command_code = data_code;
      write_csr(CSR_DATA_START, data_code);
      write_csr(CSR_COMMAND_START, command_code);
      hold_pending = 1'b1;
      random_traffic(ITEMS_PER_PHASE);

      wait_idle();
      data_code    = 8'd255;
      command_code = 8'd0;
      write_csr(CSR_DATA_START, data_code);
      write_csr(CSR_COMMAND_START, command_code);
      idling = 1'b0;
      random_traffic(ITEMS_PER_PHASE / 2);
      idling = 1'b1;
      random_traffic(ITEMS_PER_PHASE / 2);

      wait_idle();
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/ufc_pkg.sv
hw/rtl/ufc_result_fifo.sv
hw/rtl/ufc_decoder.sv
hw/rtl/unescape_xor_frame_checker_unit.sv
hw/rtl/ufc_checker.sv
bench/ufc_checker.sv
bench/unescape_xor_frame_checker_unit_tb.sv
